// File: rtl/utc_pkg.sv
// Shared types and constants for the Unicode UTF transcoder.
package utc_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [20:0] CP_LIMIT       = 21'h110000;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;

  typedef enum logic [1:0] {
    FORM_UTF8  = 2'd0,
    FORM_UTF16 = 2'd1,
    FORM_UTF32 = 2'd2
  } form_e;

  typedef enum logic [1:0] {
    ST_ACCEPT     = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_REJECT     = 2'd2
  } status_e;

  typedef enum logic {
    CFG_SOURCE_FORM = 1'b0,
    CFG_DEST_FORM   = 1'b1
  } cfg_idx_e;

  // Decoded code point handed from the front to the back.
  typedef struct packed {
    status_e     status;
    logic [2:0]  consumed;
    logic [20:0] code_point;
  } dec_t;

endpackage

// File: rtl/utc_if.sv
// Valid/ready channel interfaces for source windows and transcoded results.
interface utc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unit_a;
  logic [31:0] unit_b;
  logic [31:0] unit_c;
  logic [31:0] unit_d;
  logic [2:0]  avail;

  modport source (output valid, unit_a, unit_b, unit_c, unit_d, avail, input ready);
  modport sink   (input valid, unit_a, unit_b, unit_c, unit_d, avail, output ready);
endinterface

interface utc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  consumed;
  logic [20:0] code_point;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic [31:0] out_c;
  logic [31:0] out_d;
  logic [2:0]  out_count;

  modport source (output valid, status, consumed, code_point, out_a, out_b, out_c, out_d,
                  out_count, input ready);
  modport sink   (input valid, status, consumed, code_point, out_a, out_b, out_c, out_d,
                  out_count, output ready);
endinterface

// File: rtl/unicode_utf_transcoder.sv
// Top level: configuration registers, decode front, queue and encode back.
// A decoded request is written into the queue, then encoded and held in the output register.
// Throughput: one request per cycle; the front stalls only while the queue is full, which needs
//   output back-pressure, and resumes in the cycle after the first held result leaves.
// Reset: asynchronous, active low; clears queue and output valid, source form to UTF-8 and
//   destination form to UTF-16. No clearing pass.
module unicode_utf_transcoder import utc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  utc_in_if.sink     in_req,
  utc_out_if.source  out_res
);

  logic [1:0] src_form_q;
  logic [1:0] dst_form_q;

  // queue hand-off
  logic room;
  logic push;
  dec_t dec_front;
  logic head_valid;
  dec_t head;
  logic pop;

  // Form registers; the user must write them only while no request is in flight (the block
  // has no check for this), so the back may read the destination form live.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_form_q <= FORM_UTF8;
      dst_form_q <= FORM_UTF16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_FORM: src_form_q <= cfg_wdata_i;
        CFG_DEST_FORM:   dst_form_q <= cfg_wdata_i;
        default:         src_form_q <= src_form_q;
      endcase
    end
  end

  // Decode: classifies the window and produces status, consumed count and code point.
  utc_front u_front (
    .source_form_i (src_form_q),
    .in_req        (in_req),
    .room_i        (room),
    .push_o        (push),
    .dec_o         (dec_front)
  );

  // Decoupling queue; lets decode keep taking requests while the output stalls.
  utc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (dec_front),
    .room_o  (room),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  // Encode into the destination form and register the result.
  utc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dest_form_i (dst_form_q),
    .valid_i     (head_valid),
    .dec_i       (head),
    .pop_o       (pop),
    .out_res     (out_res)
  );

endmodule

// File: rtl/utc_front.sv
// Front end: takes a source window and decodes one code point.
module utc_front import utc_pkg::*; (
  input  logic [1:0] source_form_i,
  utc_in_if.sink     in_req,
  input  logic       room_i,
  output logic       push_o,
  output dec_t       dec_o
);

  assign in_req.ready = room_i;
  assign push_o       = in_req.valid && room_i;

  always_comb begin
    logic [2:0]  n;
    logic [7:0]  lead;
    logic        cb, cc, cd;
    logic [10:0] acc2;
    logic [15:0] acc3;
    logic [20:0] acc4;
    logic [15:0] f16;
    logic [15:0] s16;

    n    = in_req.avail[2] ? 3'd4 : in_req.avail;
    lead = in_req.unit_a[7:0];
    cb   = (in_req.unit_b[7:6] == 2'b10);
    cc   = (in_req.unit_c[7:6] == 2'b10);
    cd   = (in_req.unit_d[7:6] == 2'b10);
    acc2 = {lead[4:0], in_req.unit_b[5:0]};
    acc3 = {lead[3:0], in_req.unit_b[5:0], in_req.unit_c[5:0]};
    acc4 = {lead[2:0], in_req.unit_b[5:0], in_req.unit_c[5:0], in_req.unit_d[5:0]};
    f16  = in_req.unit_a[15:0];
    s16  = in_req.unit_b[15:0];

    dec_o.status     = ST_REJECT;
    dec_o.consumed   = 3'd1;
    dec_o.code_point = REPLACEMENT_CP;

    if (n == 3'd0) begin
      dec_o.status   = ST_INCOMPLETE;
      dec_o.consumed = 3'd0;
    end else begin
      case (source_form_i)
        FORM_UTF8: begin
          if (!lead[7]) begin
            dec_o.status     = ST_ACCEPT;
            dec_o.code_point = {13'd0, lead};
          end else if (lead[7:5] == 3'b110) begin
            if (n < 3'd2) begin
              dec_o.status = ST_INCOMPLETE;
            end else begin
              dec_o.consumed = 3'd2;
              if (cb && acc2 >= 11'h080) begin
                dec_o.status     = ST_ACCEPT;
                dec_o.code_point = {10'd0, acc2};
              end
            end
          end else if (lead[7:4] == 4'b1110) begin
            if (n < 3'd3) begin
              dec_o.status = ST_INCOMPLETE;
            end else if (!cb) begin
              dec_o.consumed = 3'd2;
            end else begin
              dec_o.consumed = 3'd3;
              // overlong or surrogate values fall through to reject
              if (cc && acc3 >= 16'h0800 && acc3[15:11] != 5'b11011) begin
                dec_o.status     = ST_ACCEPT;
                dec_o.code_point = {5'd0, acc3};
              end
            end
          end else if (lead[7:3] == 5'b11110) begin
            if (n < 3'd4) begin
              dec_o.status = ST_INCOMPLETE;
            end else if (!cb) begin
              dec_o.consumed = 3'd2;
            end else if (!cc) begin
              dec_o.consumed = 3'd3;
            end else begin
              dec_o.consumed = 3'd4;
              if (cd && acc4 >= SUPP_BASE && acc4 < CP_LIMIT) begin
                dec_o.status     = ST_ACCEPT;
                dec_o.code_point = acc4;
              end
            end
          end
        end
        FORM_UTF16: begin
          if (f16[15:10] == 6'b110110) begin
            if (n < 3'd2) begin
              dec_o.status = ST_INCOMPLETE;
            end else begin
              dec_o.consumed = 3'd2;
              if (s16[15:10] == 6'b110111) begin
                dec_o.status     = ST_ACCEPT;
                dec_o.code_point = {1'b0, f16[9:0], s16[9:0]} + SUPP_BASE;
              end
            end
          end else if (f16[15:11] != 5'b11011) begin
            dec_o.status     = ST_ACCEPT;
            dec_o.code_point = {5'd0, f16};
          end
        end
        default: begin
          if (in_req.unit_a < {11'd0, CP_LIMIT} && in_req.unit_a[31:11] != 21'h00001B) begin
            dec_o.status     = ST_ACCEPT;
            dec_o.code_point = in_req.unit_a[20:0];
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/utc_fifo.sv
// Short queue of decoded code points between front and back.
module utc_fifo import utc_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  dec_t data_i,
  output logic room_o,
  input  logic pop_i,
  output logic valid_o,
  output dec_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dec_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign room_o  = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push_ok = push_i && room_o;
  assign pop_ok  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue fill count above depth");

  a_cnt_inc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_ok && !pop_ok) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

  a_cnt_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ok && !push_ok) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count missed a pop");

  a_ptr_sync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");

endmodule

// File: rtl/utc_back.sv
// Back end: re-encodes a decoded code point into the output register.
module utc_back import utc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] dest_form_i,
  input  logic       valid_i,
  input  dec_t       dec_i,
  output logic       pop_o,
  utc_out_if.source  out_res
);

  logic        vld_q;
  logic        load;
  logic [31:0] o_d [4];
  logic [31:0] o_q [4];
  logic [2:0]  cnt_d, cnt_q;
  dec_t        dec_q;

  assign load  = !vld_q || out_res.ready;
  assign pop_o = valid_i && load;

  always_comb begin
    logic [20:0] cp;
    logic [19:0] sup;

    cp    = dec_i.code_point;
    sup   = 20'(cp - SUPP_BASE);
    o_d   = '{default: 32'd0};
    cnt_d = 3'd0;
    if (dec_i.status == ST_ACCEPT) begin
      case (dest_form_i)
        FORM_UTF8: begin
          if (cp < 21'h000080) begin
            o_d[0] = {11'd0, cp};
            cnt_d  = 3'd1;
          end else if (cp < 21'h000800) begin
            o_d[0] = {24'd0, 3'b110, cp[10:6]};
            o_d[1] = {24'd0, 2'b10, cp[5:0]};
            cnt_d  = 3'd2;
          end else if (cp < SUPP_BASE) begin
            o_d[0] = {24'd0, 4'b1110, cp[15:12]};
            o_d[1] = {24'd0, 2'b10, cp[11:6]};
            o_d[2] = {24'd0, 2'b10, cp[5:0]};
            cnt_d  = 3'd3;
          end else begin
            o_d[0] = {24'd0, 5'b11110, cp[20:18]};
            o_d[1] = {24'd0, 2'b10, cp[17:12]};
            o_d[2] = {24'd0, 2'b10, cp[11:6]};
            o_d[3] = {24'd0, 2'b10, cp[5:0]};
            cnt_d  = 3'd4;
          end
        end
        FORM_UTF16: begin
          if (cp < SUPP_BASE) begin
            o_d[0] = {11'd0, cp};
            cnt_d  = 3'd1;
          end else begin
            o_d[0] = {16'd0, 6'b110110, sup[19:10]};
            o_d[1] = {16'd0, 6'b110111, cp[9:0]};
            cnt_d  = 3'd2;
          end
        end
        default: begin
          o_d[0] = {11'd0, cp};
          cnt_d  = 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dec_q <= dec_i;
      o_q   <= o_d;
      cnt_q <= cnt_d;
    end
  end

  assign out_res.valid      = vld_q;
  assign out_res.status     = dec_q.status;
  assign out_res.consumed   = dec_q.consumed;
  assign out_res.code_point = dec_q.code_point;
  assign out_res.out_a      = o_q[0];
  assign out_res.out_b      = o_q[1];
  assign out_res.out_c      = o_q[2];
  assign out_res.out_d      = o_q[3];
  assign out_res.out_count  = cnt_q;

endmodule
